// ----- src/wsd_pkg.sv -----
`default_nettype none
package wsd_pkg;

  localparam int LEN_W             = 25;
  localparam int COUNT_WIDTH_DEF   = 25;
  localparam logic [LEN_W-1:0] MAX_FRAME_RST = LEN_W'(1048576);

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_TOO_LARGE  = 2'd0,
    ERR_BAD_OPCODE = 2'd1,
    ERR_NOT_FINAL  = 2'd2,
    ERR_NOT_MASKED = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    OPC_TEXT  = 2'd0,
    OPC_CLOSE = 2'd1,
    OPC_PING  = 2'd2,
    OPC_PONG  = 2'd3
  } opc_code_t;

  localparam logic [3:0] WS_OP_TEXT  = 4'h1;
  localparam logic [3:0] WS_OP_CLOSE = 4'h8;
  localparam logic [3:0] WS_OP_PING  = 4'h9;
  localparam logic [3:0] WS_OP_PONG  = 4'hA;

  typedef struct packed {
    logic      ok;
    opc_code_t code;
  } opc_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload_byte;
    opc_code_t         frame_opcode;
    logic [LEN_W-1:0]  frame_length;
    err_t              error_code;
    logic              last;
  } result_t;

  // Map the wire opcode nibble onto the result code; anything else is illegal.
  function automatic opc_t opc_decode(input logic [3:0] nib);
    opc_t o;
    o.ok   = 1'b1;
    o.code = OPC_TEXT;
    case (nib)
      WS_OP_TEXT:  o.code = OPC_TEXT;
      WS_OP_CLOSE: o.code = OPC_CLOSE;
      WS_OP_PING:  o.code = OPC_PING;
      WS_OP_PONG:  o.code = OPC_PONG;
      default:     o.ok   = 1'b0;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- src/wsd_core.sv -----
`default_nettype none
module wsd_core import wsd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [7:0]       data_byte,
  input  wire logic [LEN_W-1:0] max_size,
  output result_t               res,
  output logic                  res_vld
);

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             hdr0_r, hdr0_nxt;
  logic                   mask_r, mask_nxt;
  logic [LEN_W-1:0]       acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt;

  opc_t                   opc;
  logic [LEN_W-1:0]       acc_shift;
  logic                   ovf_shift;
  logic [3:0]             cnt_inc;
  logic [6:0]             len7;
  logic [LEN_W-1:0]       chk_len;
  logic                   chk_ovf;
  logic                   chk_mask;
  logic [3:0]             chk_prefix;
  logic [LEN_W:0]         chk_total;
  logic                   chk_err;
  err_t                   chk_code;
  logic [COUNT_WIDTH-1:0] len_cnt;
  logic [COUNT_WIDTH-1:0] pos_inc;
  logic                   fin;
  logic [7:0]             key_byte;
  logic                   ext_done;

  assign opc       = opc_decode(hdr0_r[3:0]);
  assign acc_shift = {acc_r[LEN_W-9:0], data_byte};
  // any bit pushed off the top makes the length larger than any register value
  assign ovf_shift = ovf_r | (|acc_r[LEN_W-1:LEN_W-8]);
  assign cnt_inc   = cnt_r + 4'd1;
  assign len7      = data_byte[6:0];
  assign len_cnt   = COUNT_WIDTH'(acc_r);
  assign pos_inc   = pos_r + COUNT_WIDTH'(1);
  assign fin       = (pos_inc == len_cnt);

  always_comb begin
    case (pos_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Frame checks once the length is complete: size, opcode, FIN, mask bit.
  always_comb begin
    chk_len    = acc_shift;
    chk_ovf    = ovf_shift;
    chk_mask   = mask_r;
    chk_prefix = 4'd2 + ((phase_r == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES);
    if (phase_r == PH_HDR1) begin
      chk_len    = LEN_W'(len7);
      chk_ovf    = 1'b0;
      chk_mask   = data_byte[7];
      chk_prefix = 4'd2;
    end
    if (chk_mask) begin
      chk_prefix = chk_prefix + KEY_BYTES;
    end
    chk_total = {1'b0, chk_len} + (LEN_W+1)'(chk_prefix);
    chk_err   = 1'b1;
    chk_code  = ERR_TOO_LARGE;
    if (chk_ovf || (chk_total > {1'b0, max_size})) begin
      chk_code = ERR_TOO_LARGE;
    end else if (!opc.ok) begin
      chk_code = ERR_BAD_OPCODE;
    end else if (!hdr0_r[7]) begin
      chk_code = ERR_NOT_FINAL;
    end else if (!chk_mask) begin
      chk_code = ERR_NOT_MASKED;
    end else begin
      chk_err = 1'b0;
    end
  end

  assign ext_done = (phase_r == PH_EXT16) ? (cnt_inc == EXT16_BYTES)
                                          : (cnt_inc == EXT64_BYTES);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HDR0: phase_nxt = PH_HDR1;
      PH_HDR1: begin
        if (len7 == LEN7_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (len7 == LEN7_EXT64) begin
          phase_nxt = PH_EXT64;
        end else begin
          phase_nxt = chk_err ? PH_HALT : PH_KEY;
        end
      end
      PH_EXT16, PH_EXT64: begin
        if (ext_done) begin
          phase_nxt = chk_err ? PH_HALT : PH_KEY;
        end
      end
      PH_KEY: begin
        if (cnt_inc == KEY_BYTES) begin
          phase_nxt = (acc_r == '0) ? PH_HDR0 : PH_DATA;
        end
      end
      PH_DATA: begin
        if (fin) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: phase_nxt = PH_HALT;
    endcase
  end

  // datapath and result
  always_comb begin
    hdr0_nxt = hdr0_r;
    mask_nxt = mask_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    key_nxt  = key_r;
    pos_nxt  = pos_r;
    res      = '0;
    res_vld  = 1'b0;
    case (phase_r)
      PH_HDR0: hdr0_nxt = data_byte;
      PH_HDR1: begin
        mask_nxt = data_byte[7];
        ovf_nxt  = 1'b0;
        cnt_nxt  = '0;
        if ((len7 == LEN7_EXT16) || (len7 == LEN7_EXT64)) begin
          acc_nxt = '0;
        end else begin
          acc_nxt = LEN_W'(len7);
          res_vld = chk_err;
        end
      end
      PH_EXT16, PH_EXT64: begin
        acc_nxt = acc_shift;
        ovf_nxt = ovf_shift;
        cnt_nxt = ext_done ? 4'd0 : cnt_inc;
        res_vld = ext_done && chk_err;
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], data_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc == KEY_BYTES) begin
          pos_nxt          = '0;
          res_vld          = 1'b1;
          res.kind         = KIND_HEADER;
          res.frame_opcode = opc.code;
          res.frame_length = LEN_W'(len_cnt);
          res.last         = (acc_r == '0);
        end
      end
      PH_DATA: begin
        pos_nxt          = pos_inc;
        res_vld          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte ^ key_byte;
        res.frame_opcode = opc.code;
        res.frame_length = LEN_W'(len_cnt);
        res.last         = fin;
      end
      default: res_vld = 1'b0;
    endcase
    if (res_vld && (res.kind == KIND_PAYLOAD) && (phase_r != PH_DATA)) begin
      res.kind       = KIND_ERROR;
      res.error_code = chk_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
    end else if (go) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hdr0_r <= hdr0_nxt;
      mask_r <= mask_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
      key_r  <= key_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/websocket_frame_deframer.sv -----
`default_nettype none
// Channel  Handshake         Payload
// in_      in_valid/in_stall  in_data_byte[7:0]
// out_     out_valid/out_stall out_kind, out_payload_byte, out_frame_opcode,
//                              out_frame_length, out_error_code, out_last
// cfg_     cfg_wr_en          cfg_wr_data[24:0] (max frame size)
//
// One byte is taken every cycle while in_stall is low; a result, where the
// byte gives one, leaves through the input register, then the result register.
// Synchronous active-low reset returns the parser to the first header byte and
// loads the frame size limit with 1 MiB.
// A held out_stall freezes the result register, and the input register then
// stalls the input side; nothing is dropped.
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_payload_byte,
  output logic [1:0]            out_frame_opcode,
  output logic [LEN_W-1:0]      out_frame_length,
  output logic [1:0]            out_error_code,
  output logic                  out_last,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             out_vld_r;
  result_t          out_r;
  logic [LEN_W-1:0] max_size_r;

  logic             adv;
  logic             go;
  result_t          res;
  logic             res_vld;

  // advance the result register whenever it is empty or being taken
  assign adv      = !out_vld_r || !out_stall;
  assign go       = in_vld_r && adv;
  // hold the input word while the parser cannot move
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      max_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
    end
  end

  wsd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .data_byte (in_byte_r),
    .max_size  (max_size_r),
    .res       (res),
    .res_vld   (res_vld)
  );

  // load a result only when the byte produced one; drop the slot otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= go && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_frame_length = out_r.frame_length;
  assign out_error_code   = out_r.error_code;
  assign out_last         = out_r.last;

endmodule
`default_nettype wire
